### sv/wrpm_pkg.sv
// shared types, constants and widths of the wheel rpm frame encoder
package wrpm_pkg;

	// velocity field width, signed Q8.16
	localparam int VELOCITY_WIDTH = 24;
	localparam int GEAR_W         = 16;

	// product of magnitude and gear ratio, widened so the saturation bit always exists
	localparam int SAT_BIT  = 35;
	localparam int PROD_W   = VELOCITY_WIDTH + GEAR_W;
	localparam int P_EXT_W  = (PROD_W > SAT_BIT) ? PROD_W : SAT_BIT + 1;

	// 60/(2*pi) scaled by 2^24
	localparam int K_W = 28;
	localparam logic [K_W-1:0] RPM_K_Q24 = 28'd160210611;

	localparam int RPM_W = 14;
	localparam logic [RPM_W-1:0] RPM_LIMIT = 14'd9999;

	// frame layout
	localparam int FRAME_LEN = 18;
	localparam int IDX_W     = 5;
	localparam logic [IDX_W-1:0] IDX_LAST = 5'(FRAME_LEN - 1);

	localparam logic [7:0] ASCII_ZERO    = 8'h30;
	localparam logic [7:0] ASCII_ONE     = 8'h31;
	localparam logic [7:0] ASCII_FIVE    = 8'h35;
	localparam logic [7:0] ASCII_SIX     = 8'h36;
	localparam logic [7:0] ASCII_SEVEN   = 8'h37;
	localparam logic [7:0] ASCII_PLUS    = 8'h2B;
	localparam logic [7:0] ASCII_MINUS   = 8'h2D;
	localparam logic [7:0] ASCII_NEWLINE = 8'h0A;

	// opcode values
	localparam logic OP_DRIVE = 1'b0;
	localparam logic OP_STOP  = 1'b1;

	// one wheel field: minus flag and four bcd digits, most significant first
	typedef struct packed {
		logic       minus;
		logic [3:0] d3;
		logic [3:0] d2;
		logic [3:0] d1;
		logic [3:0] d0;
	} wheel_field_t;

	// one finished frame waiting for the serializer
	typedef struct packed {
		logic         opcode;
		wheel_field_t right;
		wheel_field_t left;
	} frame_entry_t;

endpackage

### sv/wheel_rpm_ascii_frame_encoder.sv
// top level: command intake, two rpm lanes, frame queue and byte serializer
// each item becomes one frame of 18 bytes, sent at one byte per cycle while a frame is active
// back to back frames leave no gap; busy rises once two items are in flight
// arst_n clears valid bits, queue, serializer and sets gear_ratio to 256
// the receiver cannot stall: every strobed byte is a transfer
module wheel_rpm_ascii_frame_encoder
	import wrpm_pkg::*;
(
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [VELOCITY_WIDTH-1:0] right_velocity,
	input  logic signed [VELOCITY_WIDTH-1:0] left_velocity,
	input  logic                             opcode,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic        [GEAR_W-1:0]         cfg_data,
	output logic                             strobe,
	output logic        [7:0]                frame_byte,
	output logic                             last_byte
);

	logic [GEAR_W-1:0] gear_ratio_q;
	logic              accept;
	logic              pop;
	logic [1:0]        inflight_q;
	logic              v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic              op_s1, op_s2, op_s3, op_s4, op_s5, op_s6, op_s7;
	wheel_field_t      right_field;
	wheel_field_t      left_field;
	frame_entry_t      fifo_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        fifo_cnt_q;
	frame_entry_t      cur_q;
	logic              act_q;
	logic [IDX_W-1:0]  idx_q;
	logic [7:0]        byte_c;
	logic              strobe_q;
	logic [7:0]        byte_q;
	logic              last_q;

	// configuration register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gear_ratio_q <= 16'd256;
		end else if (cfg_valid && cfg_ready) begin
			gear_ratio_q <= cfg_data;
		end
	end

	// intake credit: items in the lanes plus those queued
	assign busy   = (inflight_q == 2'd2);
	assign accept = start && !busy;
	assign pop    = (fifo_cnt_q != 2'd0) && (!act_q || (idx_q == IDX_LAST));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 2'd0;
		end else begin
			inflight_q <= inflight_q + 2'(accept) - 2'(pop);
		end
	end

	// valid and opcode travel alongside the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= opcode;
		op_s2 <= op_s1;
		op_s3 <= op_s2;
		op_s4 <= op_s3;
		op_s5 <= op_s4;
		op_s6 <= op_s5;
		op_s7 <= op_s6;
	end

	// rpm lanes, left wheel negated
	wrpm_wheel_lane u_right (
		.clk        (clk),
		.velocity   (right_velocity),
		.negate     (1'b0),
		.gear_ratio (gear_ratio_q),
		.field      (right_field)
	);

	wrpm_wheel_lane u_left (
		.clk        (clk),
		.velocity   (left_velocity),
		.negate     (1'b1),
		.gear_ratio (gear_ratio_q),
		.field      (left_field)
	);

	// two-entry frame queue
	always_ff @(posedge clk) begin
		if (v_s7) begin
			fifo_q[wr_ptr_q] <= '{opcode: op_s7, right: right_field, left: left_field};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= 1'b0;
			rd_ptr_q   <= 1'b0;
			fifo_cnt_q <= 2'd0;
		end else begin
			if (v_s7) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fifo_cnt_q <= fifo_cnt_q + 2'(v_s7) - 2'(pop);
		end
	end

	// serializer: load a frame, then step through its bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			idx_q <= '0;
		end else if (pop) begin
			act_q <= 1'b1;
			idx_q <= '0;
		end else if (act_q) begin
			if (idx_q == IDX_LAST) begin
				act_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= fifo_q[rd_ptr_q];
		end
	end

	// byte select for the current position
	always_comb begin
		case (idx_q)
			5'd0, 5'd1:   byte_c = ASCII_SEVEN;
			5'd2, 5'd3:   byte_c = ASCII_SIX;
			5'd4:         byte_c = (cur_q.opcode == OP_STOP) ? ASCII_SEVEN : ASCII_ONE;
			5'd5:         byte_c = cur_q.right.minus ? ASCII_MINUS : ASCII_PLUS;
			5'd6:         byte_c = ASCII_ZERO | 8'(cur_q.right.d3);
			5'd7:         byte_c = ASCII_ZERO | 8'(cur_q.right.d2);
			5'd8:         byte_c = ASCII_ZERO | 8'(cur_q.right.d1);
			5'd9:         byte_c = ASCII_ZERO | 8'(cur_q.right.d0);
			5'd10:        byte_c = cur_q.left.minus ? ASCII_MINUS : ASCII_PLUS;
			5'd11:        byte_c = ASCII_ZERO | 8'(cur_q.left.d3);
			5'd12:        byte_c = ASCII_ZERO | 8'(cur_q.left.d2);
			5'd13:        byte_c = ASCII_ZERO | 8'(cur_q.left.d1);
			5'd14:        byte_c = ASCII_ZERO | 8'(cur_q.left.d0);
			5'd15, 5'd16: byte_c = ASCII_FIVE;
			default:      byte_c = ASCII_NEWLINE;
		endcase
	end

	// registered result port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= act_q;
			last_q   <= act_q && (idx_q == IDX_LAST);
		end
	end

	always_ff @(posedge clk) begin
		byte_q <= byte_c;
	end

	assign strobe     = strobe_q;
	assign frame_byte = byte_q;
	assign last_byte  = last_q;

	// queue never holds more than the credit allows
	a_fifo_le_credit: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= inflight_q)
		else $error("frame queue holds more entries than items in flight");

	// credit equals items in the lanes plus queued frames
	a_credit_sum: assert property (@(posedge clk) disable iff (!arst_n)
		($countones({v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7}) + fifo_cnt_q) == inflight_q)
		else $error("in-flight credit out of step with pipeline and queue");

	// a frame end is followed by silence or the start of the next frame
	a_frame_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last_byte) |=> (!strobe || (frame_byte == ASCII_SEVEN && !last_byte)))
		else $error("byte after frame end is not a frame start");

	// a taken item always passes v_s1 through v_s7 and reaches the queue
	a_item_arrives: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##7 v_s7)
		else $error("accepted item lost in the rpm pipeline");

endmodule

### sv/wrpm_wheel_lane.sv
// seven-stage lane that turns one wheel velocity into a signed four-digit rpm field
module wrpm_wheel_lane
	import wrpm_pkg::*;
(
	input  logic                             clk,
	input  logic signed [VELOCITY_WIDTH-1:0] velocity,
	input  logic                             negate,
	input  logic        [GEAR_W-1:0]         gear_ratio,
	output wheel_field_t                     field
);

	localparam logic [RPM_W-1:0] RECIP_1000 = 14'd8389;
	localparam logic [5:0]       RECIP_100  = 6'd41;
	localparam logic [7:0]       RECIP_10   = 8'd205;

	logic [VELOCITY_WIDTH-1:0] vel_u;
	logic [VELOCITY_WIDTH-1:0] mag_s1;
	logic                      neg_s1;
	logic [P_EXT_W-1:0]        p_s2;
	logic                      neg_s2;
	logic                      sat_s3;
	logic [45:0]               hi_s3;
	logic [44:0]               lo_s3;
	logic                      neg_s3;
	logic [RPM_W-1:0]          rpm_s4;
	logic                      neg_s4;
	logic [3:0]                d3_s5;
	logic [9:0]                r1_s5;
	logic                      minus_s5;
	logic [3:0]                d3_s6;
	logic [3:0]                d2_s6;
	logic [6:0]                r2_s6;
	logic                      minus_s6;
	wheel_field_t              field_s7;

	logic [62:0]      sum_c;
	logic [14:0]      r_c;
	logic [27:0]      q1_prod_c;
	logic [3:0]       q1_c;
	logic [RPM_W-1:0] rem1_c;
	logic [15:0]      q2_prod_c;
	logic [3:0]       q2_c;
	logic [9:0]       rem2_c;
	logic [14:0]      q3_prod_c;
	logic [3:0]       q3_c;
	logic [6:0]       rem3_c;

	assign vel_u = velocity;

	// rounding add and magnitude extraction of the scaled product
	always_comb begin
		sum_c = {hi_s3, 17'b0} + 63'(lo_s3) + (63'(1) << 47);
		r_c   = sum_c[62:48];
	end

	// digit extraction by reciprocal multiply, exact for the value ranges used
	always_comb begin
		q1_prod_c = 28'(rpm_s4) * 28'(RECIP_1000);
		q1_c      = q1_prod_c[26:23];
		rem1_c    = rpm_s4 - (14'(q1_c) * 14'd1000);
		q2_prod_c = 16'(r1_s5) * 16'(RECIP_100);
		q2_c      = q2_prod_c[15:12];
		rem2_c    = r1_s5 - (10'(q2_c) * 10'd100);
		q3_prod_c = 15'(r2_s6) * 15'(RECIP_10);
		q3_c      = q3_prod_c[14:11];
		rem3_c    = r2_s6 - (7'(q3_c) * 7'd10);
	end

	// lane stages, payload only
	always_ff @(posedge clk) begin
		// s1: magnitude and final sign
		neg_s1 <= vel_u[VELOCITY_WIDTH-1] ^ negate;
		mag_s1 <= vel_u[VELOCITY_WIDTH-1] ? (~vel_u + 1'b1) : vel_u;
		// s2: times gear ratio
		p_s2   <= {{(P_EXT_W-VELOCITY_WIDTH){1'b0}}, mag_s1}
			* {{(P_EXT_W-GEAR_W){1'b0}}, gear_ratio};
		neg_s2 <= neg_s1;
		// s3: overflow check and two partial products with the rpm constant
		sat_s3 <= |p_s2[P_EXT_W-1:SAT_BIT];
		hi_s3  <= 46'(p_s2[34:17]) * 46'(RPM_K_Q24);
		lo_s3  <= 45'(p_s2[16:0]) * 45'(RPM_K_Q24);
		neg_s3 <= neg_s2;
		// s4: round and saturate
		rpm_s4 <= (sat_s3 || (r_c > 15'(RPM_LIMIT))) ? RPM_LIMIT : r_c[RPM_W-1:0];
		neg_s4 <= neg_s3;
		// s5: thousands digit, zero rpm always gets plus
		d3_s5    <= q1_c;
		r1_s5    <= rem1_c[9:0];
		minus_s5 <= neg_s4 && (rpm_s4 != '0);
		// s6: hundreds digit
		d3_s6    <= d3_s5;
		d2_s6    <= q2_c;
		r2_s6    <= rem2_c[6:0];
		minus_s6 <= minus_s5;
		// s7: tens and ones
		field_s7.minus <= minus_s6;
		field_s7.d3    <= d3_s6;
		field_s7.d2    <= d2_s6;
		field_s7.d1    <= q3_c;
		field_s7.d0    <= rem3_c[3:0];
	end

	assign field = field_s7;

endmodule
